// File: hw/rtl/clsi_pkg.sv
// Package for the cable loss interpolator: widths, constant tables, word types and commands.
package clsi_pkg;

	// Table shape and field widths.
	localparam int NUM_FREQ_POINTS = 7;
	localparam int NUM_CABLE_TYPES = 5;
	localparam int TYPE_W = 3;
	localparam int FREQ_W = 32;
	localparam int LEN_W = 20;
	localparam int LOSS_W = 22;
	localparam int FPT_W = 13;
	localparam int ROW_W = 11;

	// Datapath widths.
	localparam int ROOT_W = 32;
	localparam int REM_W = ROOT_W + 2;
	localparam int S_W = 26;
	localparam int T_W = 23;
	localparam int X_W = S_W;
	localparam int DEN_W = 36;
	localparam int PROD_W = ROW_W + X_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int NUM_W = SUM_W + LEN_W;
	localparam int Q_W = 24;
	localparam int SEG_W = $clog2(NUM_FREQ_POINTS);
	localparam int ROOT_CYCLES = ROOT_W / 2;
	localparam int CNT_W = $clog2((Q_W > ROOT_CYCLES) ? Q_W : ROOT_CYCLES);

	localparam logic [LOSS_W-1:0] LOSS_MAX = '1;
	localparam int DEN_SCALE = 10000;

	// floor(r / 100) for any 32-bit r is (r * DIV100_MAGIC) >> DIV100_SHIFT.
	localparam logic [ROOT_W-1:0] DIV100_MAGIC = 32'd1374389535;
	localparam int DIV100_SHIFT = 37;

	// Frequency points in 10 kHz units, highest index leftmost.
	localparam logic [NUM_FREQ_POINTS-1:0][FPT_W-1:0] FPOINT = {
		13'd5010, 13'd2840, 13'd2120, 13'd1420, 13'd710, 13'd360, 13'd180
	};

	// Loss rows in 0.01 dB per 100 m; row of type 5 leftmost, highest point leftmost.
	localparam logic [NUM_CABLE_TYPES-1:0][NUM_FREQ_POINTS-1:0][ROW_W-1:0] LOSS_ROW = {
		{11'd1936, 11'd1444, 11'd1247, 11'd1017, 11'd689, 11'd492, 11'd361},
		{11'd1050, 11'd787, 11'd656, 11'd558, 11'd394, 11'd269, 11'd184},
		{11'd820, 11'd623, 11'd558, 11'd459, 11'd328, 11'd223, 11'd161},
		{11'd525, 11'd394, 11'd328, 11'd246, 11'd180, 11'd121, 11'd82},
		{11'd285, 11'd213, 11'd184, 11'd151, 11'd105, 11'd75, 11'd52}
	};

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_acc_t;

	// One digit of the bit-pair square root recurrence.
	function automatic root_acc_t root_step(input root_acc_t a, input logic [1:0] bb);
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		root_acc_t r;
		cur = {a.rem, bb};
		trial = {{(REM_W - ROOT_W){1'b0}}, a.root, 2'b01};
		if (cur >= trial) begin
			r.rem = REM_W'(cur - trial);
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem = cur[REM_W-1:0];
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [ROOT_W-1:0] point_root(input int i);
		logic [2*ROOT_W-1:0] x;
		root_acc_t acc;
		x = {ROOT_W'(FPOINT[i]), {ROOT_W{1'b0}}};
		acc = '0;
		for (int k = 0; k < ROOT_W; k++) begin
			acc = root_step(acc, x[2*ROOT_W-1-2*k -: 2]);
		end
		return acc.root;
	endfunction

	typedef logic [NUM_FREQ_POINTS-1:0][T_W-1:0] root_tab_t;
	typedef logic [NUM_FREQ_POINTS-1:0][DEN_W-1:0] den_tab_t;
	typedef logic [NUM_FREQ_POINTS-1:0][FREQ_W-1:0] thr_tab_t;

	function automatic root_tab_t make_roots();
		root_tab_t r;
		for (int i = 0; i < NUM_FREQ_POINTS; i++) begin
			r[i] = T_W'(point_root(i));
		end
		return r;
	endfunction

	// Q16.16 roots of the frequency points.
	localparam root_tab_t POINT_ROOT = make_roots();

	// Entry 0 is the low edge divisor, entry i the divisor of the segment ending at point i.
	function automatic den_tab_t make_dens();
		den_tab_t d;
		d[0] = DEN_W'(POINT_ROOT[0]) * DEN_W'(DEN_SCALE);
		for (int i = 1; i < NUM_FREQ_POINTS; i++) begin
			d[i] = DEN_W'(POINT_ROOT[i] - POINT_ROOT[i-1]) * DEN_W'(DEN_SCALE);
		end
		return d;
	endfunction

	function automatic thr_tab_t make_thresholds();
		thr_tab_t t;
		for (int i = 0; i < NUM_FREQ_POINTS; i++) begin
			t[i] = FREQ_W'(FPOINT[i]) * FREQ_W'(DEN_SCALE);
		end
		return t;
	endfunction

	localparam den_tab_t DEN_TAB = make_dens();
	localparam logic [DEN_W-1:0] DEN_LAST =
		DEN_W'(POINT_ROOT[NUM_FREQ_POINTS-1]) * DEN_W'(DEN_SCALE);
	localparam thr_tab_t THRESH = make_thresholds();

	typedef struct packed {
		logic [TYPE_W-1:0] cable_type;
		logic [FREQ_W-1:0] freq_hz;
		logic [LEN_W-1:0]  length_mm;
	} in_word_t;

	typedef struct packed {
		logic [LOSS_W-1:0] loss_mdb;
		logic              saturated;
	} out_word_t;

	// Commands from the controller to the datapath, one per step.
	typedef struct packed {
		logic load;
		logic root_step;
		logic scale;
		logic seg;
		logic mul;
		logic sum;
		logic len;
		logic check;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

endpackage

// File: hw/rtl/clsi_stream_if.sv
// Valid/ready stream interface carrying one word of a given payload type.
interface clsi_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/clsi_ctrl.sv
// Controller state machine sequencing the root, scaling, products and divide steps.
module clsi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output clsi_pkg::dp_cmd_t cmd
);
	import clsi_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_ROOT  = 10'b0000000010,
		ST_SCALE = 10'b0000000100,
		ST_SEG   = 10'b0000001000,
		ST_MUL   = 10'b0000010000,
		ST_SUM   = 10'b0000100000,
		ST_LEN   = 10'b0001000000,
		ST_CHECK = 10'b0010000000,
		ST_DIV   = 10'b0100000000,
		ST_DONE  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cnt_d = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d = CNT_W'(ROOT_CYCLES - 1);
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_SCALE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_SEG;
			end
			ST_SEG: begin
				cmd.seg = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_LEN;
			end
			ST_LEN: begin
				cmd.len = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				cnt_d = CNT_W'(Q_W - 1);
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/clsi_dp.sv
// Datapath: square root, scaling, segment selection, products, divider and output register.
module clsi_dp (
	input  logic                clk,
	input  clsi_pkg::dp_cmd_t   cmd,
	input  clsi_pkg::in_word_t  in_word,
	output clsi_pkg::out_word_t out_word
);
	import clsi_pkg::*;

	localparam int OVF_W = DEN_W + Q_W;
	localparam int DSH_W = DEN_W + Q_W - 1;

	logic [TYPE_W-1:0] type_q;
	logic [FREQ_W-1:0] freq_q;
	logic [LEN_W-1:0]  len_q;
	logic [FREQ_W-1:0] rad_q;
	root_acc_t         acc_q;
	logic [S_W-1:0]    s_q;
	logic [ROW_W-1:0]  ra_q, rb_q;
	logic [X_W-1:0]    xa_q, xb_q;
	logic [DEN_W-1:0]  den_q;
	logic [PROD_W-1:0] pa_q, pb_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NUM_W-1:0]  num_q;
	logic              ovf_q;
	logic [NUM_W-1:0]  rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [Q_W-1:0]    quo_q;
	out_word_t         out_q;

	logic [2*ROOT_W-1:0] scale_prod;
	logic              type_ok;
	logic [TYPE_W-1:0] ridx;
	logic              seg_lo, seg_hi;
	logic [SEG_W-1:0]  seg_idx;
	logic [T_W-1:0]    t0, t1, sc;
	logic [ROW_W-1:0]  row_a, row_b, row_first, row_last;
	logic [ROW_W-1:0]  ra_d, rb_d;
	logic [X_W-1:0]    xa_d, xb_d;
	logic [DEN_W-1:0]  den_d;
	logic              div_take;
	logic              sat;

	assign scale_prod = {{ROOT_W{1'b0}}, acc_q.root} * {{ROOT_W{1'b0}}, DIV100_MAGIC};

	// Segment search: the first point at or above the frequency closes the segment.
	always_comb begin
		seg_idx = SEG_W'(NUM_FREQ_POINTS - 1);
		for (int j = NUM_FREQ_POINTS - 2; j >= 1; j--) begin
			if (freq_q <= THRESH[j]) begin
				seg_idx = SEG_W'(j);
			end
		end
	end

	always_comb begin
		type_ok = (type_q != '0) && (type_q <= TYPE_W'(NUM_CABLE_TYPES));
		ridx = type_q - 1'b1;
		seg_lo = (freq_q <= THRESH[0]);
		seg_hi = (freq_q >= THRESH[NUM_FREQ_POINTS-1]);
		t0 = POINT_ROOT[seg_idx - 1'b1];
		t1 = POINT_ROOT[seg_idx];
		if (s_q < S_W'(t0)) begin
			sc = t0;
		end else if (s_q > S_W'(t1)) begin
			sc = t1;
		end else begin
			sc = T_W'(s_q);
		end
		// An unknown type reads an all-zero row, which drives the loss to zero.
		row_a = type_ok ? LOSS_ROW[ridx][seg_idx - 1'b1] : '0;
		row_b = type_ok ? LOSS_ROW[ridx][seg_idx] : '0;
		row_first = type_ok ? LOSS_ROW[ridx][0] : '0;
		row_last = type_ok ? LOSS_ROW[ridx][NUM_FREQ_POINTS-1] : '0;
		if (seg_lo) begin
			ra_d = row_first;
			xa_d = s_q;
			rb_d = '0;
			xb_d = '0;
			den_d = DEN_TAB[0];
		end else if (seg_hi) begin
			ra_d = row_last;
			xa_d = s_q;
			rb_d = '0;
			xb_d = '0;
			den_d = DEN_LAST;
		end else begin
			ra_d = row_a;
			xa_d = X_W'(t1 - sc);
			rb_d = row_b;
			xb_d = X_W'(sc - t0);
			den_d = DEN_TAB[seg_idx];
		end
	end

	assign div_take = (DSH_W'(rem_q) >= dsh_q);
	assign sat = ovf_q || (quo_q > Q_W'(LOSS_MAX));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= in_word.cable_type;
			freq_q <= in_word.freq_hz;
			len_q <= in_word.length_mm;
			rad_q <= in_word.freq_hz;
			acc_q <= '0;
		end
		if (cmd.root_step) begin
			// Two root digits per cycle; zeros follow once the frequency bits are used up.
			acc_q <= root_step(root_step(acc_q, rad_q[FREQ_W-1 -: 2]), rad_q[FREQ_W-3 -: 2]);
			rad_q <= {rad_q[FREQ_W-5:0], 4'b0000};
		end
		if (cmd.scale) begin
			s_q <= scale_prod[DIV100_SHIFT+S_W-1:DIV100_SHIFT];
		end
		if (cmd.seg) begin
			ra_q <= ra_d;
			xa_q <= xa_d;
			rb_q <= rb_d;
			xb_q <= xb_d;
			den_q <= den_d;
		end
		if (cmd.mul) begin
			pa_q <= PROD_W'(ra_q) * PROD_W'(xa_q);
			pb_q <= PROD_W'(rb_q) * PROD_W'(xb_q);
		end
		if (cmd.sum) begin
			sum_q <= SUM_W'(pa_q) + SUM_W'(pb_q);
		end
		if (cmd.len) begin
			num_q <= NUM_W'(sum_q) * NUM_W'(len_q);
		end
		if (cmd.check) begin
			ovf_q <= (OVF_W'(num_q) >= {den_q, {Q_W{1'b0}}});
			rem_q <= num_q;
			dsh_q <= {den_q, {(Q_W - 1){1'b0}}};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (div_take) begin
				rem_q <= NUM_W'(DSH_W'(rem_q) - dsh_q);
			end
			quo_q <= {quo_q[Q_W-2:0], div_take};
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.out_load) begin
			out_q.loss_mdb <= sat ? LOSS_MAX : quo_q[LOSS_W-1:0];
			out_q.saturated <= sat;
		end
	end

	assign out_word = out_q;

endmodule

// File: hw/rtl/cable_loss_sqrt_interpolator.sv
// Top level of the cable loss interpolator: controller, datapath and stream ports.
// Each input word is accepted in the idle state and passes through the square root
// (two digits a cycle), six further steps, the restoring divider and the output load,
// which waits while the output register still holds an untaken result. A new input word
// is taken only after that load, even while the finished result still waits.
// Reset (arst_n low, asynchronous) clears the controller and the output valid flag only.
module cable_loss_sqrt_interpolator (
	input  logic           clk,
	input  logic           arst_n,
	clsi_stream_if.sink    item,
	clsi_stream_if.source  result
);
	import clsi_pkg::*;

	// The controller steps through the computation one phase at a time: the square root
	// of the frequency, the division by 100 that turns it into Q16.16, the table segment choice,
	// the two row products and their sum, the length product, the overflow check, the divide.
	dp_cmd_t   cmd;
	logic      in_ready;
	logic      out_valid;
	out_word_t out_word;

	clsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// The datapath latches the input word when the controller accepts it, so the input
	// channel is free again as soon as the controller returns to idle.
	clsi_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.in_word  (item.data),
		.out_word (out_word)
	);

	// Input words are accepted only in the idle state; the result word stays in the
	// datapath's output register until the sink takes it.
	assign item.ready = in_ready;
	assign result.valid = out_valid;
	assign result.data = out_word;

endmodule

// File: tb/sv/tb_cable_loss_sqrt_interpolator.sv
// Self-checking testbench of the cable loss interpolator with a scoreboard and random traffic.
module tb_cable_loss_sqrt_interpolator;
	timeunit 1ns;
	timeprecision 1ps;

	import clsi_pkg::*;

	// The watchdog ends the run when no word moves on either channel for this many cycles.
	// The longest legal quiet stretch is the long receiver hold-off plus one computation.
	localparam int QUIET_LIMIT = 3000;
	// Cycles the receiver holds off once to back the block up into its input.
	localparam int HOLD_OFF_CYCLES = 400;
	// Settling time at the end, longer than one computation of the block.
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_WORDS = 1250;

	// The scoreboard keeps its own copy of the table and works out the loss of every
	// accepted input word in 64-bit integer arithmetic, then compares the result words
	// in order against the queue of losses still due.
	class loss_scoreboard;
		int unsigned freq_pt[NUM_FREQ_POINTS];
		int unsigned loss_tab[NUM_CABLE_TYPES][NUM_FREQ_POINTS];
		out_word_t   loss_due[$];
		int          errors;

		function new();
			freq_pt = '{180, 360, 710, 1420, 2120, 2840, 5010};
			loss_tab = '{
				'{52, 75, 105, 151, 184, 213, 285},
				'{82, 121, 180, 246, 328, 394, 525},
				'{161, 223, 328, 459, 558, 623, 820},
				'{184, 269, 394, 558, 656, 787, 1050},
				'{361, 492, 689, 1017, 1247, 1444, 1936}
			};
			errors = 0;
		endfunction

		// Largest r with r*r <= x, built one bit at a time from the top.
		function longint unsigned floor_root(longint unsigned x);
			longint unsigned r;
			longint unsigned trial;
			r = 0;
			for (int k = 31; k >= 0; k--) begin
				trial = r | (64'd1 << k);
				if (trial * trial <= x) r = trial;
			end
			return r;
		endfunction

		function longint unsigned point_hz(int i);
			return longint'(freq_pt[i]) * 10000;
		endfunction

		// Q16.16 square root of a table point given in 10 kHz units.
		function longint unsigned point_q16(int i);
			return floor_root(longint'(freq_pt[i]) << 32);
		endfunction

		function out_word_t cable_loss(in_word_t w);
			out_word_t       o;
			longint unsigned f;
			longint unsigned len;
			longint unsigned s;
			longint unsigned t0;
			longint unsigned t1;
			longint unsigned sc;
			longint unsigned n;
			longint unsigned d;
			longint unsigned loss;
			int              row;
			int              i;
			o = '0;
			f = 64'(w.freq_hz);
			len = 64'(w.length_mm);
			if (w.cable_type == 0 || w.cable_type > NUM_CABLE_TYPES || len == 0 || f == 0) begin
				return o;
			end
			row = w.cable_type - 1;
			s = floor_root(f << 32) / 100;
			if (f <= point_hz(0)) begin
				loss = (longint'(loss_tab[row][0]) * s * len) / (point_q16(0) * 10000);
			end else if (f >= point_hz(NUM_FREQ_POINTS - 1)) begin
				loss = (longint'(loss_tab[row][NUM_FREQ_POINTS - 1]) * s * len) /
					(point_q16(NUM_FREQ_POINTS - 1) * 10000);
			end else begin
				i = 1;
				while (i < NUM_FREQ_POINTS - 1 && f > point_hz(i)) i++;
				t0 = point_q16(i - 1);
				t1 = point_q16(i);
				sc = (s < t0) ? t0 : ((s > t1) ? t1 : s);
				n = longint'(loss_tab[row][i - 1]) * (t1 - sc) +
					longint'(loss_tab[row][i]) * (sc - t0);
				d = (t1 - t0) * 10000;
				loss = (d != 0) ? (n * len) / d : longint'(loss_tab[row][i]) * len / 10000;
			end
			if (loss > longint'(LOSS_MAX)) begin
				o.loss_mdb = LOSS_MAX;
				o.saturated = 1'b1;
			end else begin
				o.loss_mdb = loss[LOSS_W-1:0];
			end
			return o;
		endfunction

		function void note_word(in_word_t w);
			loss_due.push_back(cable_loss(w));
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (loss_due.size() == 0) begin
				$display("%0t: unexpected result word loss_mdb=%0d saturated=%0b",
					$time, got.loss_mdb, got.saturated);
				errors++;
				return;
			end
			want = loss_due.pop_front();
			if (got.loss_mdb !== want.loss_mdb) begin
				$display("%0t: loss_mdb mismatch, expected %0d, actual %0d",
					$time, want.loss_mdb, got.loss_mdb);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$display("%0t: saturated mismatch, expected %0b, actual %0b",
					$time, want.saturated, got.saturated);
				errors++;
			end
		endfunction

		function int pending();
			return loss_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	clsi_stream_if #(.payload_t(in_word_t))  item_ch();
	clsi_stream_if #(.payload_t(out_word_t)) result_ch();

	cable_loss_sqrt_interpolator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	loss_scoreboard sb = new();

	// Set by the stimulus to ask the receiver for one long hold-off.
	bit hold_request = 0;
	// Stretches in which a side never idles; redrawn every few dozen words.
	bit send_burst = 0;
	bit take_burst = 0;
	int send_count = 0;
	int take_count = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Every input of the block holds a known value from time zero on.
	initial begin
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		result_ch.ready <= 1'b0;
	end

	// Idle time before one word on either side: random, or none during a burst.
	function automatic int idle_cycles(bit burst);
		return burst ? 0 : $urandom_range(0, 9);
	endfunction

	// Offer one word and hold it until the block takes it. Valid stays high when the
	// next word follows with no gap, so it is never dropped and raised in one step.
	task automatic send_word(in_word_t w);
		int gap;
		if (send_count % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
		send_count++;
		gap = idle_cycles(send_burst);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= w;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_word(w);
	endtask

	task automatic offer(logic [TYPE_W-1:0] t, logic [FREQ_W-1:0] f, logic [LEN_W-1:0] l);
		in_word_t w;
		w.cable_type = t;
		w.freq_hz = f;
		w.length_mm = l;
		send_word(w);
	endtask

	// Hold further input back until every loss that is due has come out. Valid drops
	// first so that the word just taken is not offered to the block a second time.
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Random input word. Most words use a known type, and nearly half of the frequencies land
	// inside the table span or just around its points, where the interpolation does its work;
	// the rest cover the whole 32-bit range and the regions below the first point and above
	// the last one, and some words have unknown types or zero lengths.
	function automatic in_word_t random_word();
		in_word_t w;
		int       sel;
		int       idx;
		sel = $urandom_range(0, 9);
		if (sel < 8) begin
			w.cable_type = TYPE_W'($urandom_range(1, NUM_CABLE_TYPES));
		end else begin
			idx = $urandom_range(0, 2);
			w.cable_type = (idx == 0) ? 3'd0 : ((idx == 1) ? 3'd6 : 3'd7);
		end
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			w.freq_hz = $urandom;
		end else if (sel < 70) begin
			w.freq_hz = $urandom_range(1800000, 50100000);
		end else if (sel < 85) begin
			w.freq_hz = $urandom_range(0, 1800000);
		end else if (sel < 93) begin
			idx = $urandom_range(0, NUM_FREQ_POINTS - 1);
			w.freq_hz = FREQ_W'(sb.point_hz(idx) + $urandom_range(0, 2) - 1);
		end else begin
			w.freq_hz = $urandom_range(50100000, 400000000);
		end
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			w.length_mm = LEN_W'($urandom_range(0, 20'hFFFFF));
		end else if (sel < 85) begin
			w.length_mm = LEN_W'($urandom_range(0, 1000));
		end else if (sel < 95) begin
			w.length_mm = LEN_W'($urandom_range(1, 10));
		end else begin
			w.length_mm = ($urandom_range(0, 1) == 0) ? 20'd0 : 20'hFFFFF;
		end
		return w;
	endfunction

	// Receiver: takes result words with random idle time, and once holds off for a long
	// stretch so that the block backs up and stops taking input words.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (take_count % 40 == 0) take_burst = ($urandom_range(0, 3) == 0);
			take_count++;
			if (hold_request) begin
				hold_request = 0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				gap = idle_cycles(take_burst);
				if (gap > 0) begin
					result_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			sb.check_word(result_ch.data);
		end
	end

	// Watchdog: counts cycles in which no word moves on either channel.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb_cable_loss_sqrt_interpolator NOT OK");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: the table edges exactly and just inside them, a point in the
		// middle, the largest fields, the smallest nonzero ones, the unknown types, zero
		// frequency and zero length, and each segment of the table.
		offer(3'd1, 32'd1800000, 20'd100000);
		offer(3'd2, 32'd50100000, 20'd100000);
		offer(3'd3, 32'd1800001, 20'hFFFFF);
		offer(3'd4, 32'd50099999, 20'hFFFFF);
		offer(3'd5, 32'd7100000, 20'd500000);
		offer(3'd5, 32'hFFFFFFFF, 20'hFFFFF);
		offer(3'd1, 32'd1, 20'd1);
		offer(3'd1, 32'd1, 20'hFFFFF);
		offer(3'd5, 32'd10000000, 20'd12345);
		offer(3'd0, 32'd10000000, 20'd1000);
		offer(3'd6, 32'd10000000, 20'd1000);
		offer(3'd7, 32'hFFFFFFFF, 20'hFFFFF);
		offer(3'd3, 32'd0, 20'd1000);
		offer(3'd3, 32'd10000000, 20'd0);
		offer(3'd2, 32'd14200000, 20'd3000);
		offer(3'd4, 32'd28400000, 20'd77777);
		offer(3'd1, 32'd21200000, 20'd1);
		offer(3'd2, 32'd3600000, 20'd999999);
		offer(3'd3, 32'd500000, 20'd20000);
		offer(3'd4, 32'd100000000, 20'd30000);
		offer(3'd5, 32'h80000000, 20'h80000);
		offer(3'd5, 32'd1800000, 20'hFFFFF);

		// The sender pauses here until every loss due has come out.
		wait_drained();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// One long receiver hold-off while words keep being offered.
			if (n == 300) hold_request = 1;
			// A second full drain in the middle of the random traffic.
			if (n == 700) wait_drained();
			send_word(random_word());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb_cable_loss_sqrt_interpolator OK");
		end else begin
			$display("tb_cable_loss_sqrt_interpolator NOT OK");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/clsi_pkg.sv
hw/rtl/clsi_stream_if.sv
hw/rtl/clsi_ctrl.sv
hw/rtl/clsi_dp.sv
hw/rtl/cable_loss_sqrt_interpolator.sv
tb/sv/tb_cable_loss_sqrt_interpolator.sv
